[hdl/deq_pkg.sv]
`default_nettype none
package deq_pkg;

  // default number of entries in the ring
  localparam int DepthDefault = 16;

  // width of one stored value
  localparam int DataW = 32;

  // requested operation
  typedef enum logic [1:0] {
    OP_PUSH_FRONT = 2'd0,
    OP_PUSH_BACK  = 2'd1,
    OP_POP_FRONT  = 2'd2,
    OP_POP_BACK   = 2'd3
  } deq_op_t;

  // result status
  typedef enum logic [1:0] {
    ST_DONE  = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } deq_status_t;

  // memory access request for one item
  typedef struct packed {
    logic wr_en;
    logic rd_en;
  } deq_mem_cmd_t;

  // per-item result info that travels beside the memory read
  typedef struct packed {
    logic        pop_ok;
    deq_status_t status;
  } deq_meta_t;

endpackage
`default_nettype wire

[hdl/deq_ram.sv]
`default_nettype none
module deq_ram #(
  parameter int DEPTH = deq_pkg::DepthDefault,
  parameter int IDX_W = $clog2(DEPTH)
) (
  input  wire logic                      clk,
  input  wire deq_pkg::deq_mem_cmd_t     cmd,
  input  wire logic [IDX_W-1:0]          addr,
  input  wire logic [deq_pkg::DataW-1:0] wr_data,
  output logic      [deq_pkg::DataW-1:0] rd_data
);
  import deq_pkg::*;

  logic [DataW-1:0] mem [DEPTH];

  // single port, write or registered read
  always_ff @(posedge clk) begin
    if (cmd.wr_en) begin
      mem[addr] <= wr_data;
    end
    if (cmd.rd_en) begin
      rd_data <= mem[addr];
    end
  end

endmodule
`default_nettype wire

[hdl/deq_ctrl.sv]
`default_nettype none
module deq_ctrl #(
  parameter int DEPTH = deq_pkg::DepthDefault,
  parameter int IDX_W = $clog2(DEPTH),
  parameter int CNT_W = $clog2(DEPTH + 1)
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  accept,
  input  wire deq_pkg::deq_op_t      operation,
  output deq_pkg::deq_mem_cmd_t      cmd,
  output logic [IDX_W-1:0]           addr,
  output deq_pkg::deq_meta_t         meta,
  output logic [CNT_W-1:0]           count_next
);
  import deq_pkg::*;

  localparam int SUM_W = CNT_W + 1;
  localparam logic [IDX_W-1:0] LAST_IDX   = IDX_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] FULL_COUNT = CNT_W'(DEPTH);
  localparam logic [SUM_W-1:0] WRAP       = SUM_W'(DEPTH);

  logic [IDX_W-1:0] front;
  logic [IDX_W-1:0] front_next;
  logic [CNT_W-1:0] count;
  logic [IDX_W-1:0] front_dec;
  logic [IDX_W-1:0] front_inc;
  logic [SUM_W-1:0] back_raw;
  logic [SUM_W-1:0] last_raw;
  logic [SUM_W-1:0] back_wrap;
  logic [SUM_W-1:0] last_wrap;
  logic             is_push;
  logic             full;
  logic             empty;

  // ring positions around the front index
  always_comb begin
    front_dec = (front == '0) ? LAST_IDX : front - 1'b1;
    front_inc = (front == LAST_IDX) ? '0 : front + 1'b1;
    back_raw  = SUM_W'(front) + SUM_W'(count);
    last_raw  = back_raw - 1'b1;
    back_wrap = (back_raw >= WRAP) ? back_raw - WRAP : back_raw;
    last_wrap = (last_raw >= WRAP) ? last_raw - WRAP : last_raw;
  end

  // operation decode, address and pointer updates
  always_comb begin
    is_push    = (operation == OP_PUSH_FRONT) || (operation == OP_PUSH_BACK);
    full       = (count == FULL_COUNT);
    empty      = (count == '0);
    cmd        = '0;
    addr       = front;
    front_next = front;
    count_next = count;
    meta       = '{pop_ok: 1'b0, status: ST_DONE};
    if (is_push && full) begin
      meta.status = ST_FULL;
    end else if (!is_push && empty) begin
      meta.status = ST_EMPTY;
    end else begin
      case (operation)
        OP_PUSH_FRONT: begin
          cmd.wr_en  = 1'b1;
          addr       = front_dec;
          front_next = front_dec;
          count_next = count + 1'b1;
        end
        OP_PUSH_BACK: begin
          cmd.wr_en  = 1'b1;
          addr       = back_wrap[IDX_W-1:0];
          count_next = count + 1'b1;
        end
        OP_POP_FRONT: begin
          cmd.rd_en   = 1'b1;
          meta.pop_ok = 1'b1;
          addr        = front;
          front_next  = front_inc;
          count_next  = count - 1'b1;
        end
        OP_POP_BACK: begin
          cmd.rd_en   = 1'b1;
          meta.pop_ok = 1'b1;
          addr        = last_wrap[IDX_W-1:0];
          count_next  = count - 1'b1;
        end
        default: begin
          cmd = '0;
        end
      endcase
    end
    if (!accept) begin
      cmd = '0;
    end
  end

  // front index and entry count
  always_ff @(posedge clk) begin
    if (rst) begin
      front <= '0;
      count <= '0;
    end else if (accept) begin
      front <= front_next;
      count <= count_next;
    end
  end

endmodule
`default_nettype wire

[hdl/double_ended_queue.sv]
`default_nettype none
// channel | direction | handshake              | payload
// in      | input     | in_valid / in_ready    | operation, push_value
// out     | output    | out_valid / out_ready  | pop_value, status, occupancy
//
// takes one item per cycle while in_ready is high; each result passes through
// the registered memory read and then the output register
// rst clears the queue to empty; stored entries keep stale data
// a stalled output backs up through the read stage to in_ready
module double_ended_queue #(
  parameter int DEPTH = deq_pkg::DepthDefault,
  parameter int IDX_W = $clog2(DEPTH),
  parameter int CNT_W = $clog2(DEPTH + 1)
) (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             in_valid,
  output logic                                  in_ready,
  input  wire logic [1:0]                       operation,
  input  wire logic signed [deq_pkg::DataW-1:0] push_value,
  output logic                                  out_valid,
  input  wire logic                             out_ready,
  output logic signed [deq_pkg::DataW-1:0]      pop_value,
  output logic [1:0]                            status,
  output logic [CNT_W-1:0]                      occupancy
);
  import deq_pkg::*;

  logic               accept;
  logic               out_free;
  deq_mem_cmd_t       cmd;
  logic [IDX_W-1:0]   addr;
  deq_meta_t          meta;
  logic [CNT_W-1:0]   count_next;
  logic [DataW-1:0]   rd_data;
  logic               s1_valid;
  deq_meta_t          s1_meta;
  logic [CNT_W-1:0]   s1_occ;

  // handshake chain through read stage and output register
  assign out_free = !out_valid || out_ready;
  assign in_ready = !s1_valid || out_free;
  assign accept   = in_valid && in_ready;

  deq_ctrl #(
    .DEPTH (DEPTH),
    .IDX_W (IDX_W),
    .CNT_W (CNT_W)
  ) u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .accept     (accept),
    .operation  (deq_op_t'(operation)),
    .cmd        (cmd),
    .addr       (addr),
    .meta       (meta),
    .count_next (count_next)
  );

  deq_ram #(
    .DEPTH (DEPTH),
    .IDX_W (IDX_W)
  ) u_ram (
    .clk     (clk),
    .cmd     (cmd),
    .addr    (addr),
    .wr_data (push_value),
    .rd_data (rd_data)
  );

  // read stage control
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= accept;
    end
  end

  // read stage payload
  always_ff @(posedge clk) begin
    if (accept) begin
      s1_meta <= meta;
      s1_occ  <= count_next;
    end
  end

  // output register control
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_free) begin
      out_valid <= s1_valid;
    end
  end

  // output register payload
  always_ff @(posedge clk) begin
    if (out_free && s1_valid) begin
      pop_value <= s1_meta.pop_ok ? rd_data : '0;
      status    <= s1_meta.status;
      occupancy <= s1_occ;
    end
  end

`ifndef SYNTHESIS
  a_occ_bound: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> occupancy <= CNT_W'(DEPTH))
    else $error("occupancy above depth");

  a_empty_result: assert property (@(posedge clk) disable iff (rst)
    out_valid && status == ST_EMPTY |-> occupancy == '0 && pop_value == '0)
    else $error("empty pop result malformed");

  a_full_result: assert property (@(posedge clk) disable iff (rst)
    out_valid && status == ST_FULL |-> occupancy == CNT_W'(DEPTH))
    else $error("dropped push while not full");

  a_accept_stage: assert property (@(posedge clk) disable iff (rst)
    accept |=> s1_valid)
    else $error("accepted item missing from read stage");

  a_single_access: assert property (@(posedge clk) disable iff (rst)
    !(cmd.wr_en && cmd.rd_en))
    else $error("read and write in one cycle");
`endif

endmodule
`default_nettype wire

[verif/testbench.sv]
`timescale 1ns / 1ps
module testbench;
  import deq_pkg::*;

  localparam int Depth = DepthDefault;
  localparam int CntW = $clog2(Depth + 1);
  localparam logic signed [DataW-1:0] ValMin = 32'sh8000_0000;
  localparam logic signed [DataW-1:0] ValMax = 32'sh7fff_ffff;

  // one expected result
  typedef struct {
    logic signed [DataW-1:0] value;
    deq_status_t             status;
    logic [CntW-1:0]         occ;
  } deq_result_t;

  logic                    clk;
  logic                    rst;
  logic                    in_valid;
  logic                    in_ready;
  logic [1:0]              operation;
  logic signed [DataW-1:0] push_value;
  logic                    out_valid;
  logic                    out_ready;
  logic signed [DataW-1:0] pop_value;
  logic [1:0]              status;
  logic [CntW-1:0]         occupancy;

  double_ended_queue #(
    .DEPTH(Depth)
  ) u_dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .operation (operation),
    .push_value(push_value),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .pop_value (pop_value),
    .status    (status),
    .occupancy (occupancy)
  );

  // shadow copy of the ring and its pointers
  logic signed [DataW-1:0] model_ring [Depth];
  logic [3:0]              model_head;
  logic [CntW-1:0]         model_count;

  deq_result_t pending_results[$];

  int send_idle_pct;
  int recv_idle_pct;
  int hold_request;
  int hold_left;
  int items_accepted;
  int results_checked;
  int mismatch_count;
  int full_drops;
  int empty_pops;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("Verification failed");
    $finish;
  end

  // work out the result of one accepted item and update the shadow state
  task automatic predict_deque_op(input deq_op_t op, input logic signed [DataW-1:0] value);
    deq_result_t res;
    logic [3:0]  slot;
    res.value  = '0;
    res.status = ST_DONE;
    case (op)
      OP_PUSH_FRONT, OP_PUSH_BACK: begin
        if (model_count == CntW'(Depth)) begin
          res.status = ST_FULL;
          full_drops++;
        end else if (op == OP_PUSH_FRONT) begin
          model_head = model_head - 4'd1;
          model_ring[model_head] = value;
          model_count++;
        end else begin
          slot = model_head + model_count[3:0];
          model_ring[slot] = value;
          model_count++;
        end
      end
      default: begin
        if (model_count == '0) begin
          res.status = ST_EMPTY;
          empty_pops++;
        end else if (op == OP_POP_FRONT) begin
          res.value = model_ring[model_head];
          model_head = model_head + 4'd1;
          model_count--;
        end else begin
          slot = model_head + model_count[3:0] - 4'd1;
          res.value = model_ring[slot];
          model_count--;
        end
      end
    endcase
    res.occ = model_count;
    pending_results.push_back(res);
    items_accepted++;
  endtask

  // predict on each accepted item, check each accepted result
  always @(posedge clk) begin : result_check
    deq_result_t want;
    if (!rst) begin
      if (in_valid && in_ready) begin
        predict_deque_op(deq_op_t'(operation), push_value);
      end
      if (out_valid && out_ready) begin
        results_checked++;
        if (pending_results.size() == 0) begin
          if (mismatch_count < 10) begin
            $display("ERROR: result with nothing pending: value %0d status %0d occupancy %0d",
                     pop_value, status, occupancy);
          end
          mismatch_count++;
        end else begin
          want = pending_results.pop_front();
          if (pop_value !== want.value || status !== want.status ||
              occupancy !== want.occ) begin
            if (mismatch_count < 10) begin
              $display("ERROR: result %0d: expected value %0d status %0d occupancy %0d, got %0d %0d %0d",
                       results_checked, want.value, want.status, want.occ,
                       pop_value, status, occupancy);
            end
            mismatch_count++;
          end
        end
      end
    end
  end

  // output backpressure: random stalls, or a long hold when one is requested
  always @(posedge clk) begin
    if (hold_request > 0) begin
      hold_left = hold_request;
      hold_request = 0;
    end
    if (hold_left > 0) begin
      out_ready <= 1'b0;
      hold_left--;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // offer one item, with random gaps before it, and wait until it is taken
  task automatic send_item(input deq_op_t op, input logic signed [DataW-1:0] value);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid   <= 1'b1;
    operation  <= op;
    push_value <= value;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  task automatic end_burst();
    in_valid <= 1'b0;
    @(posedge clk);
  endtask

  // sender pause: let every expected result come back
  task automatic wait_for_results();
    int guard;
    guard = 0;
    while (pending_results.size() != 0 && guard < 20000) begin
      @(posedge clk);
      guard++;
    end
    repeat (8) @(posedge clk);
  endtask

  // mostly random words, with the extremes mixed in
  function automatic logic signed [DataW-1:0] pick_value();
    case ($urandom_range(7))
      0: return ValMin;
      1: return ValMax;
      2: return $urandom_range(1) ? 32'sd0 : -32'sd1;
      default: return $urandom;
    endcase
  endfunction

  // pops on an empty queue, both ends
  task automatic test_empty_pops();
    send_item(OP_POP_FRONT, ValMax);
    send_item(OP_POP_BACK, ValMin);
  endtask

  // every operation with the extreme values, then pops from both ends
  task automatic test_extremes();
    send_item(OP_PUSH_BACK, ValMax);
    send_item(OP_PUSH_FRONT, ValMin);
    send_item(OP_PUSH_BACK, 32'sd0);
    send_item(OP_PUSH_FRONT, -32'sd1);
    send_item(OP_POP_FRONT, 32'sd0);
    send_item(OP_POP_BACK, ValMax);
    send_item(OP_POP_FRONT, ValMin);
    send_item(OP_POP_BACK, -32'sd1);
    send_item(OP_POP_BACK, 32'sd0);
    end_burst();
  endtask

  // hold off the output, fill past full, then drain past empty
  task automatic test_fill_under_stall();
    int i;
    send_idle_pct = 0;
    recv_idle_pct = 0;
    hold_request = 80;
    for (i = 0; i < 20; i++) begin
      send_item(i[0] ? OP_PUSH_FRONT : OP_PUSH_BACK, pick_value());
    end
    for (i = 0; i < 20; i++) begin
      send_item(i[1] ? OP_POP_FRONT : OP_POP_BACK, pick_value());
    end
    end_burst();
    wait_for_results();
  endtask

  // random operations in runs that lean toward pushes, pops or neither
  task automatic test_random_ops(input int count, input int sender_pct, input int receiver_pct);
    int     i;
    int     push_bias;
    deq_op_t op;
    send_idle_pct = sender_pct;
    recv_idle_pct = receiver_pct;
    push_bias = 50;
    for (i = 0; i < count; i++) begin
      if (i % 32 == 0) begin
        case ($urandom_range(2))
          0: push_bias = 15;
          1: push_bias = 50;
          default: push_bias = 85;
        endcase
      end
      if ($urandom_range(99) < push_bias) begin
        op = $urandom_range(1) ? OP_PUSH_FRONT : OP_PUSH_BACK;
      end else begin
        op = $urandom_range(1) ? OP_POP_FRONT : OP_POP_BACK;
      end
      send_item(op, pick_value());
    end
    end_burst();
    wait_for_results();
  endtask

  initial begin
    rst = 1'b1;
    in_valid = 1'b0;
    operation = OP_PUSH_FRONT;
    push_value = '0;
    out_ready = 1'b0;
    model_head = '0;
    model_count = '0;
    send_idle_pct = 0;
    recv_idle_pct = 0;
    hold_request = 0;
    hold_left = 0;
    items_accepted = 0;
    results_checked = 0;
    mismatch_count = 0;
    full_drops = 0;
    empty_pops = 0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    test_empty_pops();
    test_extremes();
    test_fill_under_stall();
    test_random_ops(620, 13, 75);
    test_random_ops(620, 75, 13);
    test_random_ops(660, 0, 0);

    if (pending_results.size() != 0) begin
      $display("ERROR: %0d expected results never arrived", pending_results.size());
      mismatch_count += pending_results.size();
    end
    $display("Ran %0d deque operations and checked %0d results", items_accepted,
             results_checked);
    $display("Dropped pushes on full: %0d, pops on empty: %0d", full_drops, empty_pops);
    if (mismatch_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

[sim.f]
hdl/deq_pkg.sv
hdl/deq_ram.sv
hdl/deq_ctrl.sv
hdl/double_ended_queue.sv
verif/testbench.sv
